FILE: rtl/core/stmdc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package stmdc_pkg;

   localparam int NUM_STRINGS    = 6;
   localparam int NUM_TUNINGS    = 3;
   localparam int FREQ_FRAC_BITS = 4;

   localparam int TT_SIZE  = NUM_STRINGS * NUM_TUNINGS;
   localparam int TT_IDX_W = (TT_SIZE > 1) ? $clog2(TT_SIZE) : 1;

   localparam int FREQ_W   = 16;
   localparam int GAIN_W   = 8;
   localparam int HOLD_W   = 10;
   localparam int TIMER_W  = 24;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   localparam logic [TIMER_W-1:0] TIMER_MAX = {TIMER_W{1'b1}};
   localparam logic [HOLD_W-1:0]  HOLD_MAX  = {HOLD_W{1'b1}};

   // Register indexes on the csr port
   localparam logic [CSR_IDX_W-1:0] CSR_TOLERANCE  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DEADBAND   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_STOP_GAIN  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_LONG_PRESS = 2'd3;

   localparam logic [FREQ_W-1:0] TOLERANCE_RESET  = 16'd320;
   localparam logic [FREQ_W-1:0] DEADBAND_RESET   = 16'd3;
   localparam logic [GAIN_W-1:0] STOP_GAIN_RESET  = 8'd100;
   localparam logic [HOLD_W-1:0] LONG_PRESS_RESET = 10'd500;

   // Button bit positions
   localparam int BTN_DOWN = 0;
   localparam int BTN_MENU = 1;
   localparam int BTN_MODE = 2;
   localparam int BTN_UP   = 3;

   typedef enum logic [1:0] {
      MODE_MANUAL = 2'd0,
      MODE_AUTO   = 2'd1,
      MODE_SELECT = 2'd2
   } mode_type;

   typedef enum logic [1:0] {
      DRIVE_OFF     = 2'd0,
      DRIVE_TIGHTEN = 2'd1,
      DRIVE_LOOSEN  = 2'd2
   } drive_type;

   typedef struct packed {
      logic [3:0]        button_levels;
      logic              pitch_valid;
      logic [FREQ_W-1:0] pitch_value;
   } req_payload_type;

   typedef struct packed {
      logic              tighten_drive;
      logic              loosen_drive;
      logic [1:0]        mode;
      logic [2:0]        string_index;
      logic [1:0]        shown_tuning;
      logic [1:0]        active_tuning;
      logic [FREQ_W-1:0] target_pitch;
   } rsp_payload_type;

   typedef logic [FREQ_W-1:0] target_table_type [TT_SIZE];

   // Presets in mHz: two standard tunings and drop D
   typedef int unsigned preset_row_type [6];
   localparam preset_row_type PRESET_STD   = '{82400, 110000, 146830, 196000, 246900, 329600};
   localparam preset_row_type PRESET_DROPD = '{73400, 110000, 146830, 196000, 246900, 329600};

   function automatic target_table_type build_targets();
      target_table_type tbl;
      longint unsigned  v;
      int               ps;
      int               pt;
      for (int t = 0; t < NUM_TUNINGS; t++) begin
         for (int s = 0; s < NUM_STRINGS; s++) begin
            ps = (s < 6) ? s : 5;
            pt = (t < 3) ? t : 2;
            if (pt == 2) v = longint'(PRESET_DROPD[ps]);
            else         v = longint'(PRESET_STD[ps]);
            v = ((v << FREQ_FRAC_BITS) + 500) / 1000;
            tbl[t*NUM_STRINGS + s] = (v > 64'hFFFF) ? 16'hFFFF : v[FREQ_W-1:0];
         end
      end
      return tbl;
   endfunction

   localparam target_table_type TARGET_TABLE = build_targets();

   function automatic logic [FREQ_W-1:0] target_lookup(input logic [1:0] t,
                                                      input logic [2:0] s);
      logic [TT_IDX_W+1:0] idx;
      idx = (TT_IDX_W+2)'(t) * (TT_IDX_W+2)'(NUM_STRINGS) + (TT_IDX_W+2)'(s);
      if (idx < (TT_IDX_W+2)'(TT_SIZE)) return TARGET_TABLE[idx[TT_IDX_W-1:0]];
      else return '0;
   endfunction

endpackage

`default_nettype wire

FILE: rtl/core/stmdc_req_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface stmdc_req_if;
   logic                      valid;
   logic                      ready;
   stmdc_pkg::req_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/stmdc_rsp_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface stmdc_rsp_if;
   logic                      valid;
   logic                      ready;
   stmdc_pkg::rsp_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/string_tuner_mode_and_drive_control_core.sv
// String tuner mode and drive control. Each request is one millisecond tick with four
// button levels and an optional pitch measurement; each request yields exactly one
// response with the motor drive levels, mode, selected string, viewed and active tuning
// and the target pitch, all as they stand after the tick. The whole tick update (button
// edges, long press count, target lookup, error, one 8x16 stop-gain multiply and the
// stop timer) sits between the request handshake and the response register, so one
// request is accepted every clock while the response side keeps taking. The user must
// write registers on the csr port only while no request is in flight; the block itself
// does not enforce this.
`timescale 1ns / 1ps
`default_nettype none

module string_tuner_mode_and_drive_control_core (
   input  wire logic                                clock,
   input  wire logic                                reset,
   stmdc_req_if.sink                                req_channel,
   stmdc_rsp_if.source                              rsp_channel,
   input  wire logic                                csr_write_enable,
   input  wire logic [stmdc_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [stmdc_pkg::CSR_DATA_W-1:0]    csr_write_data
);

   localparam int FW = stmdc_pkg::FREQ_W;
   localparam int TW = stmdc_pkg::TIMER_W;
   localparam int HW = stmdc_pkg::HOLD_W;
   localparam int GW = stmdc_pkg::GAIN_W;
   localparam int PW = GW + FW;

   // configuration
   logic [FW-1:0] tolerance_ff, deadband_ff;
   logic [GW-1:0] stop_gain_ff;
   logic [HW-1:0] long_press_ff;

   // tick state
   stmdc_pkg::mode_type  mode_ff, mode_in;
   stmdc_pkg::drive_type drive_ff, drive_in;
   logic          rtm_ff, rtm_in;
   logic [2:0]    string_ff, string_in;
   logic [1:0]    view_ff, view_in;
   logic [1:0]    tuning_ff, tuning_in;
   logic [3:0]    prev_ff;
   logic [HW-1:0] hold_ff, hold_in;
   logic          armed_ff, armed_in;
   logic [TW-1:0] timer_ff, timer_in;
   logic [TW-1:0] reload_ff, reload_in;

   logic                       rsp_valid_ff;
   stmdc_pkg::rsp_payload_type rsp_payload_ff, rsp_payload_in;

   logic          accept;
   logic [3:0]    cur, rel;
   logic          pv;
   logic [FW-1:0] pitch, tgt, abserr;
   logic          neg;
   logic [PW-1:0] product;
   logic          man_tight, man_loose;

   assign req_channel.ready   = !rsp_valid_ff || rsp_channel.ready;
   assign accept              = req_channel.valid && req_channel.ready;
   assign rsp_channel.valid   = rsp_valid_ff;
   assign rsp_channel.payload = rsp_payload_ff;

   assign cur   = req_channel.payload.button_levels;
   assign pv    = req_channel.payload.pitch_valid;
   assign pitch = req_channel.payload.pitch_value;
   assign rel   = prev_ff & ~cur;

   // string step happens before the measurement, so look up with the new string
   assign tgt     = stmdc_pkg::target_lookup(tuning_ff, string_in);
   assign neg     = pitch > tgt;
   assign abserr  = neg ? (pitch - tgt) : (tgt - pitch);
   assign product = PW'(stop_gain_ff) * PW'(abserr);

   always_comb begin
      mode_in   = mode_ff;
      rtm_in    = rtm_ff;
      string_in = string_ff;
      view_in   = view_ff;
      tuning_in = tuning_ff;
      case (mode_ff)
         stmdc_pkg::MODE_MANUAL: begin
            if (rel[stmdc_pkg::BTN_MENU]) begin
               mode_in = stmdc_pkg::MODE_SELECT;
               rtm_in  = 1'b1;
            end
         end
         stmdc_pkg::MODE_AUTO: begin
            if (rel[stmdc_pkg::BTN_DOWN] && string_in != 3'd0)
               string_in = string_in - 3'd1;
            if (rel[stmdc_pkg::BTN_UP] && ({1'b0, string_in} + 4'd1 < 4'(stmdc_pkg::NUM_STRINGS)))
               string_in = string_in + 3'd1;
            if (rel[stmdc_pkg::BTN_MENU]) begin
               mode_in = stmdc_pkg::MODE_SELECT;
               rtm_in  = 1'b0;
            end
         end
         stmdc_pkg::MODE_SELECT: begin
            if (rel[stmdc_pkg::BTN_DOWN] && view_in != 2'd0)
               view_in = view_in - 2'd1;
            if (rel[stmdc_pkg::BTN_UP] && ({1'b0, view_in} + 3'd1 < 3'(stmdc_pkg::NUM_TUNINGS)))
               view_in = view_in + 2'd1;
            if (rel[stmdc_pkg::BTN_MODE])
               tuning_in = view_in;
            if (rel[stmdc_pkg::BTN_MODE] || rel[stmdc_pkg::BTN_MENU]) begin
               mode_in = rtm_ff ? stmdc_pkg::MODE_MANUAL : stmdc_pkg::MODE_AUTO;
               rtm_in  = 1'b0;
            end
         end
         default: begin
            mode_in = stmdc_pkg::MODE_MANUAL;
         end
      endcase

      // long press; a menu release in the same tick wins but still consumes the press
      hold_in  = hold_ff;
      armed_in = armed_ff;
      if (cur[stmdc_pkg::BTN_MODE]) begin
         if (mode_ff == stmdc_pkg::MODE_MANUAL || mode_ff == stmdc_pkg::MODE_AUTO) begin
            if (hold_ff != stmdc_pkg::HOLD_MAX) hold_in = hold_ff + HW'(1);
            if (armed_ff && hold_in >= long_press_ff) begin
               armed_in = 1'b0;
               if (mode_in == mode_ff)
                  mode_in = (mode_ff == stmdc_pkg::MODE_MANUAL) ? stmdc_pkg::MODE_AUTO
                                                                : stmdc_pkg::MODE_MANUAL;
            end
         end else begin
            hold_in = '0;
         end
      end else begin
         hold_in  = '0;
         armed_in = 1'b1;
      end

      drive_in  = drive_ff;
      reload_in = reload_ff;
      timer_in  = timer_ff;
      if (pv) begin
         if (mode_ff == stmdc_pkg::MODE_AUTO) begin
            reload_in = TW'(product >> stmdc_pkg::FREQ_FRAC_BITS);
            if (abserr < tolerance_ff && abserr > deadband_ff)
               drive_in = neg ? stmdc_pkg::DRIVE_LOOSEN : stmdc_pkg::DRIVE_TIGHTEN;
         end
         timer_in = (reload_in == stmdc_pkg::TIMER_MAX) ? stmdc_pkg::TIMER_MAX
                                                         : reload_in + TW'(1);
      end else if (timer_ff != '0 && timer_ff != stmdc_pkg::TIMER_MAX) begin
         timer_in = timer_ff - TW'(1);
         if (timer_in == '0) drive_in = stmdc_pkg::DRIVE_OFF;
      end

      // held buttons in manual mode override the timed drive and clear it
      man_tight = (mode_ff == stmdc_pkg::MODE_MANUAL) && cur[stmdc_pkg::BTN_DOWN];
      man_loose = (mode_ff == stmdc_pkg::MODE_MANUAL) && !cur[stmdc_pkg::BTN_DOWN]
                  && cur[stmdc_pkg::BTN_UP];
      if (man_tight || man_loose) drive_in = stmdc_pkg::DRIVE_OFF;

      rsp_payload_in.tighten_drive = man_tight ||
         (!man_loose && drive_in == stmdc_pkg::DRIVE_TIGHTEN);
      rsp_payload_in.loosen_drive  = man_loose ||
         (!man_tight && drive_in == stmdc_pkg::DRIVE_LOOSEN);
      rsp_payload_in.mode          = mode_in;
      rsp_payload_in.string_index  = string_in;
      rsp_payload_in.shown_tuning  = view_in;
      rsp_payload_in.active_tuning = tuning_in;
      rsp_payload_in.target_pitch  = stmdc_pkg::target_lookup(tuning_in, string_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tolerance_ff  <= stmdc_pkg::TOLERANCE_RESET;
         deadband_ff   <= stmdc_pkg::DEADBAND_RESET;
         stop_gain_ff  <= stmdc_pkg::STOP_GAIN_RESET;
         long_press_ff <= stmdc_pkg::LONG_PRESS_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            stmdc_pkg::CSR_TOLERANCE:  tolerance_ff  <= csr_write_data[FW-1:0];
            stmdc_pkg::CSR_DEADBAND:   deadband_ff   <= csr_write_data[FW-1:0];
            stmdc_pkg::CSR_STOP_GAIN:  stop_gain_ff  <= csr_write_data[GW-1:0];
            stmdc_pkg::CSR_LONG_PRESS: long_press_ff <= csr_write_data[HW-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= stmdc_pkg::MODE_MANUAL;
         drive_ff     <= stmdc_pkg::DRIVE_OFF;
         rtm_ff       <= 1'b0;
         string_ff    <= '0;
         view_ff      <= '0;
         tuning_ff    <= (stmdc_pkg::NUM_TUNINGS > 1) ? 2'd1 : 2'd0;
         prev_ff      <= '0;
         hold_ff      <= '0;
         armed_ff     <= 1'b1;
         timer_ff     <= '0;
         reload_ff    <= stmdc_pkg::TIMER_MAX;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            mode_ff   <= mode_in;
            drive_ff  <= drive_in;
            rtm_ff    <= rtm_in;
            string_ff <= string_in;
            view_ff   <= view_in;
            tuning_ff <= tuning_in;
            prev_ff   <= cur;
            hold_ff   <= hold_in;
            armed_ff  <= armed_in;
            timer_ff  <= timer_in;
            reload_ff <= reload_in;
         end
         if (accept) rsp_valid_ff <= 1'b1;
         else if (rsp_channel.ready) rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) rsp_payload_ff <= rsp_payload_in;
   end

endmodule

`default_nettype wire
